### sv/dh2d_pkg.sv
// ----------------------------------------------------------------------------
// dh2d_pkg
// Shared constants, word types and helpers of the 2-D density histogram.
// ----------------------------------------------------------------------------
package dh2d_pkg;

   localparam int GRID           = 256;
   localparam int COUNT_BITS     = 32;
   localparam int COORD_BITS     = 32;
   localparam int FIELD_BITS     = 32;
   localparam int IDX_OUT_BITS   = 8;
   localparam int IDX_BITS       = $clog2(GRID);
   localparam int CELLS          = GRID * GRID;
   localparam int CELL_BITS      = $clog2(CELLS);
   localparam int NUM_BITS       = COORD_BITS + IDX_BITS;
   localparam int STEP_BITS      = $clog2(IDX_BITS + 1);
   localparam int CSR_INDEX_BITS = 2;

   localparam logic signed [COORD_BITS-1:0] X_LOWER_RESET = -32'sd1073741824;
   localparam logic signed [COORD_BITS-1:0] X_UPPER_RESET =  32'sd1073741824;
   localparam logic signed [COORD_BITS-1:0] Y_LOWER_RESET = -32'sd1073741824;
   localparam logic signed [COORD_BITS-1:0] Y_UPPER_RESET =  32'sd1073741824;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_LOWER = 2'd0,
      CSR_X_UPPER = 2'd1,
      CSR_Y_LOWER = 2'd2,
      CSR_Y_UPPER = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_READ       = 1'b1
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic signed [COORD_BITS-1:0]  x_coord;
      logic signed [COORD_BITS-1:0]  y_coord;
      logic [IDX_OUT_BITS-1:0]       read_row;
      logic [IDX_OUT_BITS-1:0]       read_col;
   } req_type;

   typedef struct packed {
      logic                    binned;
      logic [IDX_OUT_BITS-1:0] row_index;
      logic [IDX_OUT_BITS-1:0] col_index;
      logic [FIELD_BITS-1:0]   cell_count;
   } rsp_type;

   function automatic logic [FIELD_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] c);
      logic [FIELD_BITS-1:0] r;
      if (64'(c) > 64'({FIELD_BITS{1'b1}})) begin
         r = '1;
      end else begin
         r = FIELD_BITS'(c);
      end
      return r;
   endfunction

endpackage

### sv/dh2d_ram.sv
// ----------------------------------------------------------------------------
// dh2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dh2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/density_histogram_2d.sv
// ----------------------------------------------------------------------------
// density_histogram_2d
// Bins signed Q3.28 points into a GRID x GRID array of saturating counters.
// ----------------------------------------------------------------------------
// The block handles one word at a time. After reset it first zeroes the
// counter memory, one cell per cycle, and takes no word until all are clear.
// An accumulate word that lands in the grid passes ST_DIVIDE, where two
// restoring dividers run side by side for column and row and produce one
// quotient bit per cycle, then ST_LOOKUP, which reads the counter, and
// ST_RESPOND, which updates it and loads the result once the output is free.
// A read word passes ST_LOOKUP and ST_RESPOND; a dropped point or an
// out-of-range read goes straight to ST_RESPOND. The result sits in an
// output register, so the next word is taken while it waits.
module density_histogram_2d
   import dh2d_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_RESPOND
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [COORD_BITS-1:0] x_lower_ff, x_lower_in;
   logic signed [COORD_BITS-1:0] x_upper_ff, x_upper_in;
   logic signed [COORD_BITS-1:0] y_lower_ff, y_lower_in;
   logic signed [COORD_BITS-1:0] y_upper_ff, y_upper_in;
   logic [CELL_BITS-1:0]         clr_ff, clr_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;
   op_type                       op_ff, op_in;
   logic                         hit_ff, hit_in;
   logic [IDX_OUT_BITS-1:0]      row_echo_ff, row_echo_in;
   logic [IDX_OUT_BITS-1:0]      col_echo_ff, col_echo_in;
   logic [COORD_BITS-1:0]        xrem_ff, xrem_in, yrem_ff, yrem_in;
   logic [COORD_BITS-1:0]        xspan_ff, xspan_in, yspan_ff, yspan_in;
   logic [IDX_BITS-1:0]          xnum_ff, xnum_in, ynum_ff, ynum_in;
   logic [IDX_BITS-1:0]          xq_ff, xq_in, yq_ff, yq_in;

   logic signed [COORD_BITS-1:0] x_pt, y_pt;
   logic                         x_ok, y_ok, rd_in_grid, accept, slot_free;
   logic [COORD_BITS-1:0]        x_off, y_off, x_span, y_span;
   logic [NUM_BITS-1:0]          x_num, y_num;
   logic [COORD_BITS:0]          x_trial, y_trial, x_diff, y_diff;
   logic                         x_ge, y_ge;
   logic [CELL_BITS-1:0]         cell_addr;
   logic                         mem_we, mem_re;
   logic [CELL_BITS-1:0]         mem_waddr;
   logic [COUNT_BITS-1:0]        mem_wdata, mem_rdata, cnt_inc;

   dh2d_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(CELLS)
   ) u_counts (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(cell_addr),
      .rd_data(mem_rdata)
   );

   assign x_pt       = req_data.x_coord;
   assign y_pt       = req_data.y_coord;
   assign x_ok       = (x_lower_ff < x_upper_ff) && (x_pt >= x_lower_ff) && (x_pt < x_upper_ff);
   assign y_ok       = (y_lower_ff < y_upper_ff) && (y_pt >= y_lower_ff) && (y_pt < y_upper_ff);
   assign x_off      = COORD_BITS'(x_pt - x_lower_ff);
   assign y_off      = COORD_BITS'(y_pt - y_lower_ff);
   assign x_span     = COORD_BITS'(x_upper_ff - x_lower_ff);
   assign y_span     = COORD_BITS'(y_upper_ff - y_lower_ff);
   assign x_num      = NUM_BITS'(x_off) * NUM_BITS'(GRID);
   assign y_num      = NUM_BITS'(y_off) * NUM_BITS'(GRID);
   assign rd_in_grid = (32'(req_data.read_row) < 32'(GRID))
                    && (32'(req_data.read_col) < 32'(GRID));

   assign x_trial = {xrem_ff, xnum_ff[IDX_BITS-1]};
   assign y_trial = {yrem_ff, ynum_ff[IDX_BITS-1]};
   assign x_diff  = x_trial - {1'b0, xspan_ff};
   assign y_diff  = y_trial - {1'b0, yspan_ff};
   assign x_ge    = x_trial >= {1'b0, xspan_ff};
   assign y_ge    = y_trial >= {1'b0, yspan_ff};

   assign cell_addr = CELL_BITS'(CELL_BITS'(yq_ff) * CELL_BITS'(GRID) + CELL_BITS'(xq_ff));
   assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      x_lower_in   = x_lower_ff;
      x_upper_in   = x_upper_ff;
      y_lower_in   = y_lower_ff;
      y_upper_in   = y_upper_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      op_in        = op_ff;
      hit_in       = hit_ff;
      row_echo_in  = row_echo_ff;
      col_echo_in  = col_echo_ff;
      xrem_in      = xrem_ff;
      yrem_in      = yrem_ff;
      xspan_in     = xspan_ff;
      yspan_in     = yspan_ff;
      xnum_in      = xnum_ff;
      ynum_in      = ynum_ff;
      xq_in        = xq_ff;
      yq_in        = yq_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cell_addr;
      mem_wdata    = (op_ff == OP_READ) ? '0 : cnt_inc;

      if (csr_we) begin
         case (csr_index)
            CSR_X_LOWER: x_lower_in = csr_wdata;
            CSR_X_UPPER: x_upper_in = csr_wdata;
            CSR_Y_LOWER: y_lower_in = csr_wdata;
            CSR_Y_UPPER: y_upper_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + CELL_BITS'(1);
            if (clr_ff == CELL_BITS'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = req_data.op;
               if (req_data.op == OP_READ) begin
                  xq_in       = IDX_BITS'(req_data.read_col);
                  yq_in       = IDX_BITS'(req_data.read_row);
                  hit_in      = rd_in_grid;
                  row_echo_in = req_data.read_row;
                  col_echo_in = req_data.read_col;
                  state_in    = rd_in_grid ? ST_LOOKUP : ST_RESPOND;
               end else begin
                  hit_in      = x_ok && y_ok;
                  row_echo_in = '0;
                  col_echo_in = '0;
                  xspan_in    = x_span;
                  yspan_in    = y_span;
                  xrem_in     = x_num[NUM_BITS-1:IDX_BITS];
                  yrem_in     = y_num[NUM_BITS-1:IDX_BITS];
                  xnum_in     = x_num[IDX_BITS-1:0];
                  ynum_in     = y_num[IDX_BITS-1:0];
                  xq_in       = '0;
                  yq_in       = '0;
                  step_in     = '0;
                  state_in    = (x_ok && y_ok) ? ST_DIVIDE : ST_RESPOND;
               end
            end
         end
         ST_DIVIDE: begin
            xrem_in = x_ge ? x_diff[COORD_BITS-1:0] : x_trial[COORD_BITS-1:0];
            yrem_in = y_ge ? y_diff[COORD_BITS-1:0] : y_trial[COORD_BITS-1:0];
            xq_in   = IDX_BITS'({xq_ff, x_ge});
            yq_in   = IDX_BITS'({yq_ff, y_ge});
            xnum_in = xnum_ff << 1;
            ynum_in = ynum_ff << 1;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(IDX_BITS - 1)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            mem_re   = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (slot_free) begin
               mem_we                 = hit_ff;
               rsp_valid_in           = 1'b1;
               rsp_data_in.binned     = hit_ff;
               rsp_data_in.row_index  = hit_ff ? IDX_OUT_BITS'(yq_ff) : row_echo_ff;
               rsp_data_in.col_index  = hit_ff ? IDX_OUT_BITS'(xq_ff) : col_echo_ff;
               rsp_data_in.cell_count = '0;
               if (hit_ff) begin
                  rsp_data_in.cell_count =
                     clip_count((op_ff == OP_READ) ? mem_rdata : cnt_inc);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         x_lower_ff   <= X_LOWER_RESET;
         x_upper_ff   <= X_UPPER_RESET;
         y_lower_ff   <= Y_LOWER_RESET;
         y_upper_ff   <= Y_UPPER_RESET;
         hit_ff       <= 1'b0;
         op_ff        <= OP_ACCUMULATE;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         x_lower_ff   <= x_lower_in;
         x_upper_ff   <= x_upper_in;
         y_lower_ff   <= y_lower_in;
         y_upper_ff   <= y_upper_in;
         hit_ff       <= hit_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
      end
      rsp_data_ff <= rsp_data_in;
      row_echo_ff <= row_echo_in;
      col_echo_ff <= col_echo_in;
      xrem_ff     <= xrem_in;
      yrem_ff     <= yrem_in;
      xspan_ff    <= xspan_in;
      yspan_ff    <= yspan_in;
      xnum_ff     <= xnum_in;
      ynum_ff     <= ynum_in;
      xq_ff       <= xq_in;
      yq_ff       <= yq_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no result may leave while the counter memory is still being zeroed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clear pass");

   // dropped points and out-of-range reads report a zero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.binned) |-> (rsp_data_ff.cell_count == '0))
      else $error("unbinned word with nonzero count");

   // outside the clear pass a counter is written only when its result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != ST_CLEAR) |-> (hit_ff && state_ff == ST_RESPOND && rsp_valid_in))
      else $error("counter write without result");

   // the read data used by the update comes from the lookup that precedes it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |=> (state_ff == ST_RESPOND && hit_ff))
      else $error("lookup not followed by update");

endmodule
